[hw/rtl/tspnn_pkg.sv]
// Package for the nearest-neighbor tour block.
// Holds the channel payload types, field widths and default parameter values.
// No dependencies.
package tspnn_pkg;

  localparam int MAX_CITIES_DEF = 16;
  localparam int COST_BITS_DEF  = 16;

  localparam int CITY_FW  = 4;
  localparam int EDGE_FW  = 16;
  localparam int NUM_FW   = 5;
  localparam int TOTAL_FW = 20;

  localparam logic [NUM_FW-1:0]   NUM_CITIES_RESET = 5'd16;
  localparam logic [NUM_FW-1:0]   NUM_CITIES_MIN   = 5'd2;
  localparam logic [TOTAL_FW-1:0] TOTAL_MAX        = 20'hFFFFF;

  typedef struct packed {
    logic [CITY_FW-1:0] row;
    logic [CITY_FW-1:0] col;
    logic [EDGE_FW-1:0] edge_cost;
    logic               start_req;
  } tspnn_in_t;

  typedef struct packed {
    logic [CITY_FW-1:0]  position;
    logic [CITY_FW-1:0]  city;
    logic [TOTAL_FW-1:0] total_cost;
    logic                last;
  } tspnn_out_t;

endpackage

[hw/rtl/tspnn_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Used for the cost matrix of the nearest-neighbor tour block. No dependencies.
module tspnn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/tsp_nearest_neighbor_tour_top.sv]
// Top level of the nearest-neighbor tour block: matrix loader and tour sequencer.
// Depends on tspnn_pkg and tspnn_ram.
//
// Usage: each input transaction writes one cost matrix entry (row, col,
// edge_cost). A transaction with start_req set writes its entry and then builds
// a tour of num_cities (clamped to 2..16) cities, starting and ending at city 0.
// The tour is emitted as one output transaction per position; the last one
// carries the closed tour cost and has last set.
// The cost matrix sits in one RAM with a single read port. Each tour step
// scans the current city's row through that port, one entry per cycle.
// The input is not ready while a tour is in progress; plain matrix writes
// are taken every cycle while no tour runs.
// A result sits in an output register while the next step is computed; if
// the receiver stalls, the sequencer waits with the next result.
// Reset clears the sequencer and output valid and sets num_cities to 16;
// the matrix contents are undefined until written.
// The cfg_wdata value is taken at any edge with cfg_we high and should only
// change while no tour is running.
module tsp_nearest_neighbor_tour_top #(
  parameter int MAX_CITIES = tspnn_pkg::MAX_CITIES_DEF,
  parameter int COST_BITS  = tspnn_pkg::COST_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  tspnn_pkg::tspnn_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output tspnn_pkg::tspnn_out_t out_data,
  input  logic                  cfg_we,
  input  logic [tspnn_pkg::NUM_FW-1:0] cfg_wdata
);

  import tspnn_pkg::*;

  localparam int CITY_W   = $clog2(MAX_CITIES);
  localparam int ADDR_W   = 2 * CITY_W;
  localparam int DEPTH    = 1 << ADDR_W;
  localparam int TOUR_MAX = (MAX_CITIES < 16) ? MAX_CITIES : 16;
  localparam int SUM_W    = ((COST_BITS > TOTAL_FW) ? COST_BITS : TOTAL_FW) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EMIT,
    S_SCAN,
    S_DRAIN,
    S_STEP,
    S_CLOSE,
    S_CLOSE_WAIT
  } state_t;

  state_t                state_r, state_nxt;
  logic [NUM_FW-1:0]     num_cities_r, num_cities_nxt;
  logic [MAX_CITIES-1:0] visited_r, visited_nxt;
  logic [CITY_W-1:0]     cur_r, cur_nxt;
  logic [CITY_W-1:0]     j_r, j_nxt;
  logic [CITY_FW-1:0]    pos_r, pos_nxt;
  logic [TOTAL_FW-1:0]   run_r, run_nxt;
  logic [COST_BITS-1:0]  best_r, best_nxt;
  logic [CITY_W-1:0]     best_city_r, best_city_nxt;
  logic                  found_r, found_nxt;
  logic                  pend_valid_r, pend_valid_nxt;
  logic [CITY_W-1:0]     pend_city_r, pend_city_nxt;
  logic                  out_valid_r, out_valid_nxt;
  tspnn_out_t            out_data_r, out_data_nxt;

  logic [NUM_FW-1:0]     n_cities;
  logic [NUM_FW-1:0]     n_m1;
  logic                  in_fire;
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic [ADDR_W-1:0]     rd_addr;
  logic [COST_BITS-1:0]  rd_data;
  logic [COST_BITS-1:0]  addend;
  logic [SUM_W-1:0]      sum;
  logic [TOTAL_FW-1:0]   sum_sat;
  logic                  out_free;
  logic                  pos_is_last;

  always_comb begin
    if (num_cities_r < NUM_CITIES_MIN) begin
      n_cities = NUM_CITIES_MIN;
    end else if (32'(num_cities_r) > TOUR_MAX) begin
      n_cities = NUM_FW'(TOUR_MAX);
    end else begin
      n_cities = num_cities_r;
    end
  end

  assign n_m1        = n_cities - NUM_FW'(1);
  assign in_ready    = (state_r == S_IDLE);
  assign in_fire     = in_valid && in_ready;
  assign wr_en       = in_fire && (32'(in_data.row) < MAX_CITIES)
                       && (32'(in_data.col) < MAX_CITIES);
  assign wr_addr     = {CITY_W'(in_data.row), CITY_W'(in_data.col)};
  assign rd_addr     = (state_r == S_SCAN) ? {cur_r, j_r} : {cur_r, CITY_W'(0)};
  assign out_free    = !out_valid_r || out_ready;
  assign pos_is_last = ({1'b0, pos_r} == n_m1);

  assign addend  = (state_r == S_STEP) ? best_r : rd_data;
  assign sum     = SUM_W'(run_r) + SUM_W'(addend);
  assign sum_sat = (sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_FW-1:0];

  tspnn_ram #(
    .WIDTH (COST_BITS),
    .DEPTH (DEPTH)
  ) u_cost_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (COST_BITS'(in_data.edge_cost)),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt      = state_r;
    num_cities_nxt = cfg_we ? cfg_wdata : num_cities_r;
    visited_nxt    = visited_r;
    cur_nxt        = cur_r;
    j_nxt          = j_r;
    pos_nxt        = pos_r;
    run_nxt        = run_r;
    best_nxt       = best_r;
    best_city_nxt  = best_city_r;
    found_nxt      = found_r;
    pend_valid_nxt = 1'b0;
    pend_city_nxt  = j_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;

    if (pend_valid_r && (!found_r || (rd_data < best_r))) begin
      best_nxt      = rd_data;
      best_city_nxt = pend_city_r;
      found_nxt     = 1'b1;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire && in_data.start_req) begin
          visited_nxt    = '0;
          visited_nxt[0] = 1'b1;
          cur_nxt        = '0;
          pos_nxt        = '0;
          run_nxt        = '0;
          state_nxt      = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.position   = pos_r;
          out_data_nxt.city       = CITY_FW'(cur_r);
          out_data_nxt.total_cost = pos_is_last ? run_r : '0;
          out_data_nxt.last       = pos_is_last;
          if (pos_is_last) begin
            state_nxt = S_IDLE;
          end else begin
            j_nxt     = '0;
            found_nxt = 1'b0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        pend_valid_nxt = !visited_r[j_r];
        pend_city_nxt  = j_r;
        j_nxt          = j_r + CITY_W'(1);
        if (32'(j_r) == 32'(n_m1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_STEP;
      end
      S_STEP: begin
        run_nxt                  = sum_sat;
        cur_nxt                  = best_city_r;
        visited_nxt[best_city_r] = 1'b1;
        pos_nxt                  = pos_r + CITY_FW'(1);
        if ({1'b0, pos_r} == n_m1 - NUM_FW'(1)) begin
          state_nxt = S_CLOSE;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_CLOSE: begin
        state_nxt = S_CLOSE_WAIT;
      end
      S_CLOSE_WAIT: begin
        run_nxt   = sum_sat;
        state_nxt = S_EMIT;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      num_cities_r <= NUM_CITIES_RESET;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      found_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      num_cities_r <= num_cities_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      found_r      <= found_nxt;
    end
    visited_r   <= visited_nxt;
    cur_r       <= cur_nxt;
    j_r         <= j_nxt;
    pos_r       <= pos_nxt;
    run_r       <= run_nxt;
    best_r      <= best_nxt;
    best_city_r <= best_city_nxt;
    pend_city_r <= pend_city_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[tb/sv/tsp_nearest_neighbor_tour_top_test.sv]
// Self-checking testbench for the nearest-neighbor tour block.
// Depends on tspnn_pkg and tsp_nearest_neighbor_tour_top. It loads cost matrices,
// predicts every tour transaction on its own, and checks the results field by field.
module tsp_nearest_neighbor_tour_top_test;
  import tspnn_pkg::*;

  localparam int NCITY         = MAX_CITIES_DEF;
  localparam int IDLE_LIMIT    = 4000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 250;
  localparam int END_CYCLES    = NCITY * (NCITY + 3) + 16;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  tspnn_in_t         in_data;
  logic              out_valid;
  logic              out_ready;
  tspnn_out_t        out_data;
  logic              cfg_we;
  logic [NUM_FW-1:0] cfg_wdata;

  logic [EDGE_FW-1:0] cost_tbl [NCITY][NCITY];
  bit                 loaded [NCITY][NCITY];
  logic [NUM_FW-1:0]  cities_cfg;
  tspnn_out_t         pending_steps[$];
  int                 mismatches = 0;
  int                 items_sent = 0;
  int                 burst_left = 0;
  int                 gap_max = 0;
  int                 recv_mode = 0;
  int                 hold_req = 0;
  int                 hold_ack = 0;
  int                 idle_cycles = 0;

  tsp_nearest_neighbor_tour_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [TOTAL_FW-1:0] add_capped(input logic [TOTAL_FW-1:0] a,
                                                     input logic [EDGE_FW-1:0] b);
    logic [TOTAL_FW:0] s;
    s = a + b;
    return (s > TOTAL_MAX) ? TOTAL_MAX : s[TOTAL_FW-1:0];
  endfunction

  // Builds the nearest-neighbor tour for the current matrix and queues its steps.
  function automatic void predict_tour();
    int                  n;
    int                  here;
    int                  best_city;
    logic [EDGE_FW-1:0]  best;
    logic [TOTAL_FW-1:0] run;
    bit [NCITY-1:0]      seen;
    bit                  found;
    tspnn_out_t          step;
    n = (cities_cfg < NUM_CITIES_MIN) ? NUM_CITIES_MIN :
        ((cities_cfg > NCITY) ? NCITY : cities_cfg);
    here = 0;
    seen = NCITY'(1);
    run = '0;
    for (int k = 0; k < n; k++) begin
      if (k > 0) begin
        found = 1'b0;
        best = '0;
        best_city = 0;
        for (int j = 0; j < n; j++) begin
          if (!seen[j] && (!found || cost_tbl[here][j] < best)) begin
            found = 1'b1;
            best = cost_tbl[here][j];
            best_city = j;
          end
        end
        run = add_capped(run, best);
        here = best_city;
        seen[here] = 1'b1;
      end
      step = '0;
      step.position = CITY_FW'(k);
      step.city = CITY_FW'(here);
      if (k == n - 1) begin
        run = add_capped(run, cost_tbl[here][0]);
        step.total_cost = run;
        step.last = 1'b1;
      end
      pending_steps = {pending_steps, step};
    end
  endfunction

  function automatic logic [EDGE_FW-1:0] pick_cost();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return EDGE_FW'($urandom_range(0, 3));
      default: return EDGE_FW'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    mismatches++;
  endtask

  task automatic send_entry(input logic [CITY_FW-1:0] row, input logic [CITY_FW-1:0] col,
                            input logic [EDGE_FW-1:0] cost, input bit go);
    tspnn_in_t item;
    int        gap;
    item.row = row;
    item.col = col;
    item.edge_cost = cost;
    item.start_req = go;
    if (burst_left <= 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
      if (gap_max != 0 && $urandom_range(0, 15) == 0) begin
        gap = 40;
      end
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    items_sent++;
    cost_tbl[row][col] = cost;
    loaded[row][col] = 1'b1;
    if (go) begin
      predict_tour();
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_steps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_cities(input logic [NUM_FW-1:0] code);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= code;
    @(posedge clk);
    cfg_we <= 1'b0;
    cities_cfg = code;
  endtask

  task automatic load_block(input int n);
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        if (!loaded[r][c]) begin
          send_entry(CITY_FW'(r), CITY_FW'(c), pick_cost(), 1'b0);
        end
      end
    end
  endtask

  task automatic test_two_cities();
    gap_max = 0;
    recv_mode = 0;
    set_cities(NUM_CITIES_MIN);
    send_entry(4'd0, 4'd0, '0, 1'b0);
    send_entry(4'd0, 4'd1, '1, 1'b0);
    send_entry(4'd1, 4'd0, '1, 1'b0);
    send_entry(4'd1, 4'd1, '0, 1'b1);
  endtask

  task automatic test_equal_costs();
    gap_max = 2;
    recv_mode = 1;
    set_cities(5'd3);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        send_entry(CITY_FW'(r), CITY_FW'(c), 16'd5, (r == 2 && c == 2));
      end
    end
    send_entry(4'd0, 4'd2, '0, 1'b1);
  endtask

  task automatic test_count_below_range();
    gap_max = 0;
    recv_mode = 2;
    set_cities(5'd0);
    send_entry(4'd1, 4'd0, 16'h5555, 1'b1);
    set_cities(5'd1);
    send_entry(4'd0, 4'd1, 16'hAAAA, 1'b1);
  endtask

  task automatic test_random_tours();
    int                first;
    int                tours;
    int                n;
    int                extra;
    logic [NUM_FW-1:0] code;
    first = items_sent;
    tours = 0;
    n = 2;
    while (items_sent - first < RANDOM_ITEMS) begin
      if (tours == 5) begin
        n = NCITY;
      end else if ($urandom_range(0, 2) != 0) begin
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(2, NCITY) : $urandom_range(2, 6);
      end
      case ($urandom_range(0, 2))
        0: gap_max = 0;
        1: gap_max = 3;
        default: gap_max = 12;
      endcase
      recv_mode = $urandom_range(0, 2);
      if (n == 2) begin
        code = NUM_FW'($urandom_range(0, 2));
      end else if (n == NCITY) begin
        code = NUM_FW'($urandom_range(NCITY, 31));
      end else begin
        code = NUM_FW'(n);
      end
      if (code != cities_cfg || $urandom_range(0, 3) == 0) begin
        set_cities(code);
      end
      load_block(n);
      extra = $urandom_range(0, 8);
      repeat (extra) begin
        if ($urandom_range(0, 4) == 0) begin
          send_entry(CITY_FW'($urandom_range(0, NCITY - 1)),
                     CITY_FW'($urandom_range(0, NCITY - 1)), pick_cost(), 1'b0);
        end else begin
          send_entry(CITY_FW'($urandom_range(0, n - 1)), CITY_FW'($urandom_range(0, n - 1)),
                     pick_cost(), 1'b0);
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        send_entry(CITY_FW'($urandom_range(0, NCITY - 1)),
                   CITY_FW'($urandom_range(0, NCITY - 1)), pick_cost(), 1'b1);
      end else begin
        send_entry(CITY_FW'($urandom_range(0, n - 1)), CITY_FW'($urandom_range(0, n - 1)),
                   pick_cost(), 1'b1);
      end
      tours++;
    end
  endtask

  task automatic test_output_backpressure();
    gap_max = 0;
    recv_mode = 1;
    set_cities(5'd31);
    load_block(NCITY);
    hold_req++;
    send_entry(4'd15, 4'd15, pick_cost(), 1'b1);
    repeat (6) begin
      send_entry(CITY_FW'($urandom_range(0, NCITY - 1)),
                 CITY_FW'($urandom_range(0, NCITY - 1)), pick_cost(), 1'b0);
    end
    send_entry(4'd0, 4'd0, pick_cost(), 1'b1);
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_ack) begin
        hold_ack = hold_req;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        case (recv_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_results
    tspnn_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_steps.size() == 0) begin
        report_mismatch("transaction with nothing pending, city", 0, 32'(out_data.city));
      end else begin
        want = pending_steps.pop_front();
        if (out_data.position !== want.position) begin
          report_mismatch("position", 32'(want.position), 32'(out_data.position));
        end
        if (out_data.city !== want.city) begin
          report_mismatch("city", 32'(want.city), 32'(out_data.city));
        end
        if (out_data.total_cost !== want.total_cost) begin
          report_mismatch("total_cost", 32'(want.total_cost), 32'(out_data.total_cost));
        end
        if (out_data.last !== want.last) begin
          report_mismatch("last", 32'(want.last), 32'(out_data.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    cities_cfg = NUM_CITIES_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_two_cities();
    test_equal_costs();
    test_count_below_range();
    test_random_tours();
    test_output_backpressure();
    wait_idle();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_steps.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
